@@ rtl/kmer_similarity_sorted_row_unit_assert.svh @@
// Assertion macros shared by the k-mer similarity sorted row unit.
`ifndef KMER_SIMILARITY_SORTED_ROW_UNIT_ASSERT_SVH
`define KMER_SIMILARITY_SORTED_ROW_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kssr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kssr assertion failed");

`endif

@@ rtl/kssr_pkg.sv @@
// Shared types and constants of the k-mer similarity sorted row unit.
package kssr_pkg;

    localparam int SCORE_W    = 10;
    localparam int SUB_W      = 8;
    localparam int LETTER_W   = 5;
    localparam int QUERY_W    = 6;
    localparam int QUERY_SPAN = 2 ** QUERY_W;
    localparam int INDEX_W    = 6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic signed [SUB_W-1:0]   sub_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ rtl/kssr_in_if.sv @@
// Input channel interface: substitution writes and k-mer queries.
interface kssr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [kssr_pkg::LETTER_W-1:0]        sub_row;
    logic [kssr_pkg::LETTER_W-1:0]        sub_col;
    kssr_pkg::sub_t                       sub_value;
    logic [kssr_pkg::QUERY_W-1:0]         query_kmer;

    modport source (output valid, output cmd, output sub_row, output sub_col,
                    output sub_value, output query_kmer, input ready);
    modport sink (input valid, input cmd, input sub_row, input sub_col,
                  input sub_value, input query_kmer, output ready);
endinterface

@@ rtl/kssr_out_if.sv @@
// Output channel interface: sorted score and index pairs.
interface kssr_out_if;
    logic                          valid;
    logic                          ready;
    kssr_pkg::score_t              pair_score;
    logic [kssr_pkg::INDEX_W-1:0]  kmer_index;
    logic                          last;

    modport source (output valid, output pair_score, output kmer_index, output last,
                    input ready);
    modport sink (input valid, input pair_score, input kmer_index, input last,
                  output ready);
endinterface

@@ rtl/kssr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kssr_cell.sv @@
// One cell of the insertion sorting chain, holding one score and index.
module kssr_cell #(
    parameter int IW = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kssr_pkg::cell_ctrl_t ctrl,
    input  kssr_pkg::score_t     new_score,
    input  logic [IW-1:0]        new_idx,
    input  logic                 prev_valid,
    input  kssr_pkg::score_t     prev_score,
    input  logic [IW-1:0]        prev_idx,
    input  logic                 prev_keep,
    input  logic                 next_valid,
    input  kssr_pkg::score_t     next_score,
    input  logic [IW-1:0]        next_idx,
    output logic                 valid,
    output kssr_pkg::score_t     score,
    output logic [IW-1:0]        idx,
    output logic                 keep
);

    logic             valid_reg;
    logic             valid_next;
    kssr_pkg::score_t score_reg;
    kssr_pkg::score_t score_next;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    idx_next;

    // A cell keeps its entry when it is at least the incoming score, which keeps ties stable.
    assign keep = valid_reg && (score_reg >= new_score);

    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        idx_next   = idx_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    valid_next = 1'b1;
                    score_next = new_score;
                    idx_next   = new_idx;
                end
                else
                begin
                    valid_next = prev_valid;
                    score_next = prev_score;
                    idx_next   = prev_idx;
                end
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = next_valid;
            score_next = next_score;
            idx_next   = next_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        idx_reg   <= idx_next;
    end

    assign valid = valid_reg;
    assign score = score_reg;
    assign idx   = idx_reg;

endmodule

@@ rtl/kmer_similarity_sorted_row_unit.sv @@
// Top level of the k-mer similarity sorted row unit: scoring sequencer and sorting chain.
//
//   channel | direction | transaction
//   req     | in        | cmd 0: write one substitution entry; cmd 1: query one k-mer row
//   rsp     | out       | one (pair_score, kmer_index, last) pair of the sorted row
//
// A query scores one target k-mer per cycle, with KMER copies of the substitution table read in
// parallel, then the sorting chain shifts out one pair per cycle while rsp is ready.
// After reset the chain is empty; substitution entries are undefined until written.
// Requests are taken only between queries. A stalled rsp holds the chain in place.
`include "kmer_similarity_sorted_row_unit_assert.svh"

module kmer_similarity_sorted_row_unit #(
    parameter int ALPHABET = 4,
    parameter int KMER     = 3
) (
    input logic        clk,
    input logic        rst_n,
    kssr_in_if.sink    req,
    kssr_out_if.source rsp
);

    localparam int LW    = $clog2(ALPHABET);
    localparam int COUNT = ALPHABET ** KMER;
    localparam int IW    = $clog2(COUNT);
    localparam int CW    = $clog2(COUNT + 1);
    localparam int DEPTH = ALPHABET * ALPHABET;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCORE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    typedef logic [KMER-1:0][LW-1:0] letters_t;
    typedef letters_t [kssr_pkg::QUERY_SPAN-1:0] qtab_t;

    // Letters of every query index, letter 0 least significant, wrapping at ALPHABET**KMER.
    function automatic qtab_t build_qtab();
        qtab_t    tab;
        letters_t d;
        logic     carry;
        d = '0;
        for (int v = 0; v < kssr_pkg::QUERY_SPAN; v++)
        begin
            tab[v] = d;
            carry  = 1'b1;
            for (int p = 0; p < KMER; p++)
            begin
                if (carry)
                begin
                    if (int'(d[p]) == ALPHABET - 1)
                    begin
                        d[p] = '0;
                    end
                    else
                    begin
                        d[p]  = d[p] + LW'(1);
                        carry = 1'b0;
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    letters_t         qlet_reg;
    letters_t         qlet_next;
    letters_t         tlet_reg;
    letters_t         tlet_next;
    logic [CW-1:0]    iss_cnt_reg;
    logic [CW-1:0]    iss_cnt_next;
    logic             iss_on_reg;
    logic             iss_on_next;
    logic             s1_valid_reg;
    logic [IW-1:0]    s1_idx_reg;
    logic             s2_valid_reg;
    kssr_pkg::score_t s2_score_reg;
    logic [IW-1:0]    s2_idx_reg;
    logic [CW-1:0]    ins_cnt_reg;
    logic [CW-1:0]    ins_cnt_next;
    logic [CW-1:0]    out_cnt_reg;
    logic [CW-1:0]    out_cnt_next;

    logic                 req_fire;
    logic                 query_start;
    logic                 wr_en;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr [KMER];
    logic [kssr_pkg::SUB_W-1:0] rd_data [KMER];
    logic [IW-1:0]        cur_idx;
    kssr_pkg::score_t     sum;
    logic                 out_fire;
    kssr_pkg::cell_ctrl_t ctrl;

    logic             c_valid [COUNT+2];
    kssr_pkg::score_t c_score [COUNT+2];
    logic [IW-1:0]    c_idx   [COUNT+2];
    logic             c_keep  [COUNT+2];
    logic [IW+kssr_pkg::INDEX_W-1:0] idx_ext;

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign query_start = req_fire && (req.cmd == kssr_pkg::CMD_QUERY);
    assign wr_en       = req_fire && (req.cmd == kssr_pkg::CMD_WRITE)
                         && (int'(req.sub_row) < ALPHABET) && (int'(req.sub_col) < ALPHABET);
    assign waddr       = AW'(int'(req.sub_row) * ALPHABET + int'(req.sub_col));

    for (genvar p = 0; p < KMER; p++)
    begin : g_ram
        assign raddr[p] = AW'(int'(qlet_reg[p]) * ALPHABET + int'(tlet_reg[p]));
        kssr_ram #(
            .WIDTH (kssr_pkg::SUB_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en),
            .waddr (waddr),
            .wdata (req.sub_value),
            .raddr (raddr[p]),
            .rdata (rd_data[p])
        );
    end

    always_comb
    begin
        cur_idx = IW'(tlet_reg[KMER-1]);
        for (int p = KMER - 2; p >= 0; p--)
        begin
            cur_idx = IW'(int'(cur_idx) * ALPHABET + int'(tlet_reg[p]));
        end
    end

    always_comb
    begin
        sum = '0;
        for (int p = 0; p < KMER; p++)
        begin
            sum = sum + kssr_pkg::score_t'({{(kssr_pkg::SCORE_W - kssr_pkg::SUB_W)
                                               {rd_data[p][kssr_pkg::SUB_W-1]}}, rd_data[p]});
        end
    end

    // Targets step with letter 0 most significant, so the last letter counts fastest.
    always_comb
    begin
        logic carry;
        tlet_next    = tlet_reg;
        iss_cnt_next = iss_cnt_reg;
        iss_on_next  = iss_on_reg;
        carry        = 1'b1;
        if (query_start)
        begin
            tlet_next    = '0;
            iss_cnt_next = '0;
            iss_on_next  = 1'b1;
        end
        else if (iss_on_reg)
        begin
            for (int p = KMER - 1; p >= 0; p--)
            begin
                if (carry)
                begin
                    if (int'(tlet_reg[p]) == ALPHABET - 1)
                    begin
                        tlet_next[p] = '0;
                    end
                    else
                    begin
                        tlet_next[p] = tlet_reg[p] + LW'(1);
                        carry        = 1'b0;
                    end
                end
            end
            if (iss_cnt_reg == CW'(COUNT - 1))
            begin
                iss_on_next = 1'b0;
            end
            else
            begin
                iss_cnt_next = iss_cnt_reg + CW'(1);
            end
        end
    end

    assign out_fire    = rsp.valid && rsp.ready;
    assign ctrl.clear  = query_start;
    assign ctrl.insert = s2_valid_reg;
    assign ctrl.shift  = out_fire;

    always_comb
    begin
        state_next   = state_reg;
        qlet_next    = qlet_reg;
        ins_cnt_next = ins_cnt_reg;
        out_cnt_next = out_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_start)
                begin
                    qlet_next    = QTAB[req.query_kmer];
                    ins_cnt_next = '0;
                    state_next   = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                if (s2_valid_reg)
                begin
                    ins_cnt_next = ins_cnt_reg + CW'(1);
                    if (ins_cnt_reg == CW'(COUNT - 1))
                    begin
                        out_cnt_next = CW'(COUNT);
                        state_next   = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    out_cnt_next = out_cnt_reg - CW'(1);
                    if (out_cnt_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iss_on_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            iss_cnt_reg  <= '0;
            ins_cnt_reg  <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_on_reg   <= iss_on_next;
            s1_valid_reg <= iss_on_reg;
            s2_valid_reg <= s1_valid_reg;
            iss_cnt_reg  <= iss_cnt_next;
            ins_cnt_reg  <= ins_cnt_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qlet_reg     <= qlet_next;
        tlet_reg     <= tlet_next;
        s1_idx_reg   <= cur_idx;
        s2_score_reg <= sum;
        s2_idx_reg   <= s1_idx_reg;
    end

    assign c_valid[0]       = 1'b0;
    assign c_score[0]       = '0;
    assign c_idx[0]         = '0;
    assign c_keep[0]        = 1'b1;
    assign c_valid[COUNT+1] = 1'b0;
    assign c_score[COUNT+1] = '0;
    assign c_idx[COUNT+1]   = '0;
    assign c_keep[COUNT+1]  = 1'b0;

    for (genvar i = 1; i <= COUNT; i++)
    begin : g_cell
        kssr_cell #(
            .IW (IW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_score  (s2_score_reg),
            .new_idx    (s2_idx_reg),
            .prev_valid (c_valid[i-1]),
            .prev_score (c_score[i-1]),
            .prev_idx   (c_idx[i-1]),
            .prev_keep  (c_keep[i-1]),
            .next_valid (c_valid[i+1]),
            .next_score (c_score[i+1]),
            .next_idx   (c_idx[i+1]),
            .valid      (c_valid[i]),
            .score      (c_score[i]),
            .idx        (c_idx[i]),
            .keep       (c_keep[i])
        );
    end

    assign idx_ext        = {{kssr_pkg::INDEX_W{1'b0}}, c_idx[1]};
    assign rsp.valid      = (state_reg == ST_DRAIN);
    assign rsp.pair_score = c_score[1];
    assign rsp.kmer_index = idx_ext[kssr_pkg::INDEX_W-1:0];
    assign rsp.last       = (out_cnt_reg == CW'(1));

    `KSSR_ASSERT_IMP(a_no_request_in_drain, clk, rst_n, rsp.valid, !req.ready)
    `KSSR_ASSERT_IMP(a_head_sorted, clk, rst_n, rsp.valid && c_valid[2], c_score[1] >= c_score[2])
    `KSSR_ASSERT_NEXT(a_last_frees_input, clk, rst_n, rsp.valid && rsp.ready && rsp.last, req.ready)
    `KSSR_ASSERT_IMP(a_insert_while_scoring, clk, rst_n, s2_valid_reg, state_reg == ST_SCORE)

endmodule
